### rtl/dwr_pkg.sv
// Package with the request, response, command and state types of the deque.
`default_nettype none
package dwr_pkg;

  typedef enum logic [1:0] {
    FUNC_PUSH_HEAD = 2'd0,
    FUNC_PUSH_TAIL = 2'd1,
    FUNC_POP_HEAD  = 2'd2,
    FUNC_REVERSE   = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value_in;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] value_out;
    logic [4:0]         count;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic capture;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/dwr_ctrl.sv
// Controller state machine that sequences one request at a time.
`default_nettype none
module dwr_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output dwr_pkg::cmd_t    cmd
);

  dwr_pkg::state_t state;
  dwr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dwr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_stall   = 1'b1;
    rsp_valid   = 1'b0;
    cmd.start   = 1'b0;
    cmd.capture = 1'b0;
    unique case (state)
      dwr_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = dwr_pkg::ST_EXEC;
        end
      end
      dwr_pkg::ST_EXEC: begin
        // The store read issued at accept is available now.
        cmd.capture = 1'b1;
        state_next  = dwr_pkg::ST_RESP;
      end
      dwr_pkg::ST_RESP: begin
        rsp_valid = 1'b1;
        if (!rsp_stall) begin
          state_next = dwr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dwr_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_start_then_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> cmd.capture)
    else $error("capture did not follow start");
  a_capture_then_resp: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> rsp_valid)
    else $error("response did not follow capture");
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid || cmd.capture) |-> req_stall)
    else $error("request taken while another is in flight");
`endif

endmodule
`default_nettype wire

### rtl/dwr_dp.sv
// Datapath of the deque: ring store, pointers, count, direction flag and response register.
`default_nettype none
module dwr_dp #(
  parameter int DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire dwr_pkg::cmd_t cmd,
  input  wire dwr_pkg::req_t req,
  output dwr_pkg::rsp_t      rsp
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int CW_EXT = (CW > 5) ? CW : 5;
  localparam logic [CW:0]   DEPTH_W = (CW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;

  logic [AW-1:0] front_index;
  logic [AW-1:0] front_index_next;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] entry_count_next;
  logic          reversed;
  logic          reversed_next;
  logic          ok;
  logic          ok_next;
  logic          pop_ok;
  logic          pop_ok_next;

  logic [CW:0]       slot_sum;
  logic [AW-1:0]     back_slot;
  logic [AW-1:0]     front_prev;
  logic [AW-1:0]     front_succ;
  logic [AW-1:0]     back_prev;
  logic              full;
  logic              empty;
  logic              push_head;
  logic              push_tail;
  logic              pop_head;
  logic              flip;
  logic              at_front;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [CW_EXT-1:0] count_ext;

  always_comb begin
    slot_sum = (CW + 1)'(front_index) + (CW + 1)'(entry_count);
    if (slot_sum >= DEPTH_W) begin
      slot_sum = slot_sum - DEPTH_W;
    end
    back_slot  = slot_sum[AW-1:0];
    front_prev = (front_index == '0) ? LAST : front_index - 1'b1;
    front_succ = (front_index == LAST) ? '0 : front_index + 1'b1;
    back_prev  = (back_slot == '0) ? LAST : back_slot - 1'b1;
    full       = ((CW + 1)'(entry_count) == DEPTH_W);
    empty      = (entry_count == '0);
    push_head  = (req.func == dwr_pkg::FUNC_PUSH_HEAD);
    push_tail  = (req.func == dwr_pkg::FUNC_PUSH_TAIL);
    pop_head   = (req.func == dwr_pkg::FUNC_POP_HEAD);
    flip       = (req.func == dwr_pkg::FUNC_REVERSE);
    // Logical head sits at the physical front unless the order is reversed.
    at_front   = (push_head && !reversed) || (push_tail && reversed);
  end

  always_comb begin
    front_index_next = front_index;
    entry_count_next = entry_count;
    reversed_next    = reversed;
    ok_next          = ok;
    pop_ok_next      = pop_ok;
    wr_en            = 1'b0;
    wr_addr          = at_front ? front_prev : back_slot;
    rd_addr          = reversed ? back_prev : front_index;
    if (cmd.start) begin
      ok_next     = 1'b0;
      pop_ok_next = 1'b0;
      if ((push_head || push_tail) && !full) begin
        wr_en            = 1'b1;
        entry_count_next = entry_count + 1'b1;
        ok_next          = 1'b1;
        if (at_front) begin
          front_index_next = front_prev;
        end
      end else if (pop_head && !empty) begin
        entry_count_next = entry_count - 1'b1;
        ok_next          = 1'b1;
        pop_ok_next      = 1'b1;
        if (!reversed) begin
          front_index_next = front_succ;
        end
      end else if (flip && !empty) begin
        reversed_next = !reversed;
        ok_next       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      entry_count <= '0;
      reversed    <= 1'b0;
      ok          <= 1'b0;
      pop_ok      <= 1'b0;
    end else begin
      front_index <= front_index_next;
      entry_count <= entry_count_next;
      reversed    <= reversed_next;
      ok          <= ok_next;
      pop_ok      <= pop_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= req.value_in;
    end
    if (cmd.start) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign count_ext = CW_EXT'(entry_count);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rsp.ok        <= ok;
      rsp.value_out <= pop_ok ? rd_data : '0;
      rsp.count     <= count_ext[4:0];
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (CW + 1)'(entry_count) <= DEPTH_W)
    else $error("entry count above depth");
  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    (AW + 1)'(front_index) < (AW + 1)'(DEPTH))
    else $error("front index outside the ring");
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (cmd.start && pop_head && empty) |=>
      ($stable(entry_count) && $stable(front_index) && !ok && !pop_ok))
    else $error("remove from empty store changed state");
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (cmd.start && (push_head || push_tail) && full) |=>
      ($stable(entry_count) && $stable(front_index) && !ok))
    else $error("insert into full store changed state");
`endif

endmodule
`default_nettype wire

### rtl/deque_with_reverse.sv
// After a request is accepted, the store read is registered and then the response register is loaded;
// the response is then offered until it is taken.
// Only one request is in flight; the request side stalls until the response is taken.
// Reset clears the front pointer, the count and the direction flag; the store is not cleared.
// The store is a DEPTH-word memory with one write and one registered read port.
`default_nettype none
module deque_with_reverse #(
  parameter int DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire dwr_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output dwr_pkg::rsp_t      rsp
);

  dwr_pkg::cmd_t cmd;

  dwr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  dwr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule
`default_nettype wire

### test/tb_deque_with_reverse.sv
// Self-checking testbench for the deque with reverse: directed corner cases, then random traffic.
`timescale 1ns / 100ps

module tb_deque_with_reverse;

  localparam int DEPTH = 16;
  localparam int RANDOM_REQUESTS = 1300;
  localparam int HOLD_AT_RESPONSE = 500;
  localparam int HOLD_CYCLES = 300;

  // Tracks the deque contents and checks every response in order.
  class deque_scoreboard;
    logic [31:0] slots [DEPTH];
    int front_pos;
    int held;
    bit flipped;
    dwr_pkg::rsp_t answers_due [$];
    int failures;
    int responses_seen;

    function new();
      front_pos = 0;
      held = 0;
      flipped = 1'b0;
      failures = 0;
      responses_seen = 0;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    // Physical slot just past the last held entry.
    function int back_slot();
      return (front_pos + held) % DEPTH;
    endfunction

    function dwr_pkg::rsp_t apply_request(dwr_pkg::req_t r);
      dwr_pkg::rsp_t a;
      a = '0;
      case (dwr_pkg::func_t'(r.func))
        dwr_pkg::FUNC_PUSH_HEAD, dwr_pkg::FUNC_PUSH_TAIL: begin
          if (held < DEPTH) begin
            // The logical head is the physical front unless the order is flipped.
            if ((dwr_pkg::func_t'(r.func) == dwr_pkg::FUNC_PUSH_HEAD) != flipped) begin
              front_pos = (front_pos + DEPTH - 1) % DEPTH;
              slots[front_pos] = r.value_in;
            end else begin
              slots[back_slot()] = r.value_in;
            end
            held++;
            a.ok = 1'b1;
          end
        end
        dwr_pkg::FUNC_POP_HEAD: begin
          if (held != 0) begin
            if (!flipped) begin
              a.value_out = slots[front_pos];
              front_pos = (front_pos + 1) % DEPTH;
            end else begin
              a.value_out = slots[(front_pos + held - 1) % DEPTH];
            end
            held--;
            a.ok = 1'b1;
          end
        end
        default: begin
          if (held != 0) begin
            flipped = !flipped;
            a.ok = 1'b1;
          end
        end
      endcase
      a.count = held[4:0];
      return a;
    endfunction

    function void note_request(dwr_pkg::req_t r);
      answers_due.push_back(apply_request(r));
    endfunction

    function void check_response(dwr_pkg::rsp_t got);
      dwr_pkg::rsp_t want;
      responses_seen++;
      if (answers_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("response %0d with no request outstanding: ok %0b value_out %0d count %0d",
                   responses_seen, got.ok, got.value_out, got.count);
        return;
      end
      want = answers_due.pop_front();
      if (got.ok !== want.ok || got.value_out !== want.value_out ||
          got.count !== want.count) begin
        failures++;
        if (failures <= 10)
          $display("response %0d mismatch (expected/actual): ok %0b/%0b %s %0d/%0d %s %0d/%0d",
                   responses_seen, want.ok, got.ok, "value_out", want.value_out,
                   got.value_out, "count", want.count, got.count);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  dwr_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall;
  dwr_pkg::rsp_t rsp;

  deque_scoreboard board;
  bit sender_idles;
  int requests_sent;

  deque_with_reverse #(.DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input dwr_pkg::func_t f, input logic [31:0] v);
    int gap;
    dwr_pkg::req_t r;
    r.func = f;
    r.value_in = v;
    gap = sender_idles ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    board.note_request(r);
    requests_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] extremes [4];
    extremes[0] = 32'h0000_0000;
    extremes[1] = 32'hFFFF_FFFF;
    extremes[2] = 32'h8000_0000;
    extremes[3] = 32'h7FFF_FFFF;
    if ($urandom_range(0, 7) == 0)
      return extremes[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  // Mode 0 leans toward filling, mode 1 toward draining, mode 2 is even.
  function automatic dwr_pkg::func_t pick_func(int mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      0: return roll < 35 ? dwr_pkg::FUNC_PUSH_HEAD : roll < 70 ? dwr_pkg::FUNC_PUSH_TAIL :
                roll < 85 ? dwr_pkg::FUNC_POP_HEAD : dwr_pkg::FUNC_REVERSE;
      1: return roll < 10 ? dwr_pkg::FUNC_PUSH_HEAD : roll < 20 ? dwr_pkg::FUNC_PUSH_TAIL :
                roll < 85 ? dwr_pkg::FUNC_POP_HEAD : dwr_pkg::FUNC_REVERSE;
      default: return roll < 25 ? dwr_pkg::FUNC_PUSH_HEAD :
                      roll < 50 ? dwr_pkg::FUNC_PUSH_TAIL :
                      roll < 75 ? dwr_pkg::FUNC_POP_HEAD : dwr_pkg::FUNC_REVERSE;
    endcase
  endfunction

  // Response side: random stalls, quiet stretches, and one long hold-off.
  initial begin : response_side
    int gap;
    bit receiver_idles;
    rsp_stall = 1'b0;
    receiver_idles = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (board.responses_seen % 50 == 0)
        receiver_idles = $urandom_range(0, 2) != 0;
      gap = receiver_idles ? $urandom_range(0, 11) : 0;
      if (board.responses_seen == HOLD_AT_RESPONSE)
        gap = HOLD_CYCLES;
      if (gap > 0) begin
        rsp_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
      board.check_response(rsp);
      @(negedge clk);
    end
  end

  initial begin : request_side
    int mode;
    int run_len;
    board = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    requests_sent = 0;
    sender_idles = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Refusals on an empty deque, both ends, flips, and emptying then refilling.
    send_request(dwr_pkg::FUNC_POP_HEAD, 32'h1234_5678);
    send_request(dwr_pkg::FUNC_REVERSE, 32'h0);
    send_request(dwr_pkg::FUNC_PUSH_HEAD, 32'h7FFF_FFFF);
    send_request(dwr_pkg::FUNC_PUSH_TAIL, 32'h8000_0000);
    send_request(dwr_pkg::FUNC_REVERSE, 32'hFFFF_FFFF);
    send_request(dwr_pkg::FUNC_POP_HEAD, 32'h0);
    send_request(dwr_pkg::FUNC_REVERSE, 32'h0);
    send_request(dwr_pkg::FUNC_POP_HEAD, 32'h0);
    send_request(dwr_pkg::FUNC_PUSH_TAIL, 32'h0000_0000);
    for (int i = 0; i < DEPTH - 1; i++)
      send_request(i % 2 ? dwr_pkg::FUNC_PUSH_HEAD : dwr_pkg::FUNC_PUSH_TAIL,
                   i % 2 ? 32'hFFFF_FFFF - i : 32'h8000_0000 + i);
    // The deque is full now: both inserts must be refused.
    send_request(dwr_pkg::FUNC_PUSH_HEAD, 32'hFFFF_FFFF);
    send_request(dwr_pkg::FUNC_PUSH_TAIL, 32'h7FFF_FFFF);

    while (requests_sent < RANDOM_REQUESTS + 26) begin
      mode = $urandom_range(0, 2);
      run_len = $urandom_range(20, 60);
      sender_idles = $urandom_range(0, 2) != 0;
      repeat (run_len)
        send_request(pick_func(mode), pick_value());
    end
    req_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin : run_limit
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
rtl/dwr_pkg.sv
rtl/dwr_ctrl.sv
rtl/dwr_dp.sv
rtl/deque_with_reverse.sv
test/tb_deque_with_reverse.sv
